// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers; the bodies vanish for synthesis.
// Users must have clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define FED_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define FED_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FED_ASSERT_IMPLY(lbl, ante, cons)
`define FED_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/fed_pkg.sv =====
// ----------------------------------------------------------------------------
// fed_pkg
// Types and fixed-point constants for the flat-earth distance block.
// ----------------------------------------------------------------------------
package fed_pkg;

    localparam logic [32:0] DEG7_K      = 33'd2012227209;
    localparam logic [30:0] PI_Q29      = 31'd1686629713;
    localparam logic [30:0] HALF_PI_Q29 = 31'd843314856;
    localparam logic [31:0] R1_Q8       = 32'd1627328512;
    localparam logic [31:0] R2_Q8       = 32'd1632803072;
    localparam logic [63:0] R1_SQ       = 64'(R1_Q8) * 64'(R1_Q8);
    localparam logic [32:0] R_DIFF      = 33'(R2_Q8 - R1_Q8);
    localparam logic [32:0] R_SUM       = 33'(R1_Q8) + 33'(R2_Q8);
    localparam logic [33:0] CORDIC_X0   = 34'd652032874;
    localparam logic [33:0] ONE_Q30     = 34'd1073741824;
    localparam logic [32:0] MUL_100     = 33'd100;
    localparam logic [32:0] MUL_1E6     = 33'd1000000;

    localparam logic ALU_MUL  = 1'b0;
    localparam logic ALU_SQRT = 1'b1;

    typedef struct packed {
        logic        start;
        logic        op;
        logic [63:0] a;
        logic [32:0] b;
        logic [63:0] init;
    } fed_alu_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [64:0] res;
    } fed_alu_rsp_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [30:0] cos_q30;
    } fed_cos_rsp_t;

    function automatic logic [28:0] fed_atan(input logic [4:0] idx);
        logic [28:0] r;
        unique case (idx)
            5'd0:    r = 29'd421657428;
            5'd1:    r = 29'd248918915;
            5'd2:    r = 29'd131521918;
            5'd3:    r = 29'd66762579;
            5'd4:    r = 29'd33510843;
            5'd5:    r = 29'd16771758;
            5'd6:    r = 29'd8387925;
            5'd7:    r = 29'd4194219;
            5'd8:    r = 29'd2097141;
            5'd9:    r = 29'd1048575;
            5'd30:   r = 29'd0;
            5'd31:   r = 29'd0;
            default: r = 29'd1 << (5'd29 - idx);
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/fed_alu.sv =====
// ----------------------------------------------------------------------------
// fed_alu
// Shared shift-add multiplier and bit-pair integer square root, 65-bit adder.
// ----------------------------------------------------------------------------
module fed_alu (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fed_pkg::fed_alu_req_t req,
    output fed_pkg::fed_alu_rsp_t rsp
);
    import fed_pkg::*;

    logic        busy_reg;
    logic        op_reg;
    logic [64:0] acc_reg;
    logic [63:0] a_reg;
    logic [32:0] b_reg;
    logic [63:0] bit_reg;

    logic [63:0] trial;
    logic [64:0] addend;
    logic [64:0] sum;
    logic        finish;
    logic        ge;

    assign trial  = a_reg + bit_reg;
    assign addend = (op_reg == ALU_MUL) ? {1'b0, a_reg} : ~{1'b0, trial};
    assign sum    = acc_reg + addend + {64'd0, op_reg == ALU_SQRT};
    assign ge     = !sum[64];
    assign finish = busy_reg && ((op_reg == ALU_MUL) ? (b_reg == '0) : (bit_reg == '0));

    assign rsp.busy = busy_reg;
    assign rsp.done = finish;
    assign rsp.res  = (op_reg == ALU_SQRT) ? {1'b0, a_reg} : acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
        end
        else if (finish)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            op_reg <= req.op;
            if (req.op == ALU_MUL)
            begin
                acc_reg <= {1'b0, req.init};
                a_reg   <= req.a;
                b_reg   <= req.b;
            end
            else
            begin
                acc_reg <= {1'b0, req.a};
                a_reg   <= '0;
                bit_reg <= 64'd1 << 62;
            end
        end
        else if (busy_reg && !finish)
        begin
            if (op_reg == ALU_MUL)
            begin
                if (b_reg[0])
                begin
                    acc_reg <= sum;
                end
                a_reg <= a_reg << 1;
                b_reg <= b_reg >> 1;
            end
            else
            begin
                if (ge)
                begin
                    acc_reg <= {1'b0, sum[63:0]};
                    a_reg   <= (a_reg >> 1) + bit_reg;
                end
                else
                begin
                    a_reg <= a_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
        end
    end

endmodule

// ===== rtl/fed_cordic.sv =====
// ----------------------------------------------------------------------------
// fed_cordic
// Rotation-mode CORDIC, one micro-rotation per cycle, returns |cos| in Q30.
// ----------------------------------------------------------------------------
module fed_cordic #(
    parameter int CORDIC_ITERATIONS = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [30:0]           angle,
    output fed_pkg::fed_cos_rsp_t rsp
);
    import fed_pkg::*;

    localparam int CW = $clog2(CORDIC_ITERATIONS + 1);

    logic                busy_reg;
    logic [CW-1:0]       i_reg;
    logic signed [33:0]  x_reg;
    logic signed [33:0]  y_reg;
    logic signed [33:0]  z_reg;

    logic signed [33:0]  xs;
    logic signed [33:0]  ys;
    logic signed [33:0]  at;
    logic signed [33:0]  fold;
    logic signed [33:0]  a_in;
    logic                finish;

    assign a_in   = $signed({3'b0, angle});
    assign fold   = (a_in > $signed({3'b0, HALF_PI_Q29})) ? ($signed({3'b0, PI_Q29}) - a_in)
                                                          : a_in;
    assign xs     = x_reg >>> i_reg;
    assign ys     = y_reg >>> i_reg;
    assign at     = $signed({5'b0, fed_atan(5'(i_reg))});
    assign finish = busy_reg && (i_reg == CW'(CORDIC_ITERATIONS));

    assign rsp.busy    = busy_reg;
    assign rsp.done    = finish;
    assign rsp.cos_q30 = x_reg[33] ? '0 :
                         (x_reg > $signed(ONE_Q30)) ? ONE_Q30[30:0] : x_reg[30:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (finish)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            i_reg <= '0;
            x_reg <= $signed(CORDIC_X0);
            y_reg <= '0;
            z_reg <= fold[33] ? -fold : fold;
        end
        else if (busy_reg && !finish)
        begin
            i_reg <= i_reg + 1'b1;
            if (!z_reg[33])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
    end

endmodule

// ===== rtl/flat_earth_distance_cached_radius.sv =====
// ----------------------------------------------------------------------------
// flat_earth_distance_cached_radius
// Equirectangular distance between two GPS fixes with a cached meridian radius.
//
//   channel   dir  handshake                      payload
//   s_axis    in   s_axis_tvalid/s_axis_tready    two points, 1e-7 deg
//   m_axis    out  m_axis_tvalid/m_axis_tready    distance_cm, saturated flag
//   cfg       in   cfg_wr_en                      refresh_threshold_urad
//
// One item runs up to 14 shift-add multiplies on the shared ALU (one multiplier
// bit per cycle, ends at the top set bit), up to two 32-step square roots and
// CORDIC_ITERATIONS CORDIC steps, all run back to back. The radius refresh adds
// three multiplies and a root only when it fires.
// Reset is asynchronous; the result register holds until taken, and the next
// item is accepted meanwhile but stalls before loading it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module flat_earth_distance_cached_radius #(
    parameter int CORDIC_ITERATIONS = 24
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // lat_a[30:0], lon_a[62:31], lat_b[93:63], lon_b[125:94]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,  // distance_cm[31:0]
    output logic         m_axis_tuser,  // saturated
    input  logic         cfg_wr_en,
    input  logic [20:0]  cfg_wr_data
);
    import fed_pkg::*;

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_LAT  = 5'd1;
    localparam logic [4:0] ST_DLAT = 5'd2;
    localparam logic [4:0] ST_DLON = 5'd3;
    localparam logic [4:0] ST_COS  = 5'd4;
    localparam logic [4:0] ST_CHK  = 5'd5;
    localparam logic [4:0] ST_C2   = 5'd6;
    localparam logic [4:0] ST_T    = 5'd7;
    localparam logic [4:0] ST_R2   = 5'd8;
    localparam logic [4:0] ST_RSQ  = 5'd9;
    localparam logic [4:0] ST_TH   = 5'd10;
    localparam logic [4:0] ST_HM   = 5'd11;
    localparam logic [4:0] ST_H    = 5'd12;
    localparam logic [4:0] ST_VM   = 5'd13;
    localparam logic [4:0] ST_V    = 5'd14;
    localparam logic [4:0] ST_HH   = 5'd15;
    localparam logic [4:0] ST_VV   = 5'd16;
    localparam logic [4:0] ST_DSQ  = 5'd17;
    localparam logic [4:0] ST_FIN  = 5'd18;

    logic [4:0]         state_reg;
    logic               pend_reg;
    logic [20:0]        thr_reg;
    logic signed [31:0] ref_reg;
    logic [30:0]        radius_reg;
    logic               lat_neg_reg;
    logic [30:0]        lat_mag_reg;
    logic [31:0]        dlat_mag_reg;
    logic [32:0]        dlon_mag_reg;
    logic [30:0]        lat1_reg;
    logic [31:0]        adlat_reg;
    logic [32:0]        adlon_reg;
    logic [30:0]        cos_reg;
    logic [63:0]        tmp_reg;
    logic [34:0]        h_reg;
    logic [34:0]        v_reg;
    logic [31:0]        rdist_reg;
    logic               rsat_reg;
    logic               out_valid_reg;
    logic [31:0]        dist_reg;
    logic               sat_reg;

    fed_alu_req_t       alu_req;
    fed_alu_rsp_t       alu_rsp;
    fed_cos_rsp_t       cos_rsp;
    logic               cos_start;
    logic               alu_state;
    logic               alu_op;
    logic               alu_fire;
    logic               out_load;
    logic               fin_stall;

    logic signed [31:0] la;
    logic signed [31:0] lb;
    logic signed [32:0] oa;
    logic signed [32:0] ob;
    logic signed [31:0] dlat;
    logic signed [32:0] dlon;
    logic signed [31:0] lat1_s;
    logic signed [32:0] diff;
    logic [32:0]        adiff;
    logic [63:0]        thr_scaled;
    logic [64:0]        res;

    assign la   = 32'(signed'(s_axis_tdata[30:0]));
    assign oa   = 33'(signed'(s_axis_tdata[62:31]));
    assign lb   = 32'(signed'(s_axis_tdata[93:63]));
    assign ob   = 33'(signed'(s_axis_tdata[125:94]));
    assign dlat = lb - la;
    assign dlon = ob - oa;

    assign lat1_s     = lat_neg_reg ? -$signed({1'b0, lat1_reg}) : $signed({1'b0, lat1_reg});
    assign diff       = 33'(ref_reg) - 33'(lat1_s);
    assign adiff      = diff[32] ? 33'(-diff) : 33'(diff);
    assign thr_scaled = {14'd0, thr_reg, 29'd0} + 64'd500000;
    assign res        = alu_rsp.res;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = dist_reg;
    assign m_axis_tuser  = sat_reg;
    assign out_load      = (state_reg == ST_FIN) && (!out_valid_reg || m_axis_tready);
    assign alu_fire      = pend_reg && alu_rsp.done;
    assign cos_start     = (state_reg == ST_COS) && !pend_reg;
    assign fin_stall     = (state_reg == ST_FIN) && out_valid_reg && !m_axis_tready;

    always_comb
    begin
        alu_state    = 1'b1;
        alu_op       = ALU_MUL;
        alu_req.a    = '0;
        alu_req.b    = '0;
        alu_req.init = '0;
        unique case (state_reg)
            ST_LAT:
            begin
                alu_req.a    = {33'd0, lat_mag_reg};
                alu_req.b    = DEG7_K;
                alu_req.init = 64'd1 << 30;
            end
            ST_DLAT:
            begin
                alu_req.a    = {32'd0, dlat_mag_reg};
                alu_req.b    = DEG7_K;
                alu_req.init = 64'd1 << 30;
            end
            ST_DLON:
            begin
                alu_req.a    = {31'd0, dlon_mag_reg};
                alu_req.b    = DEG7_K;
                alu_req.init = 64'd1 << 30;
            end
            ST_CHK:
            begin
                alu_req.a = {31'd0, adiff};
                alu_req.b = MUL_1E6;
            end
            ST_C2:
            begin
                alu_req.a    = {33'd0, cos_reg};
                alu_req.b    = {2'd0, cos_reg};
                alu_req.init = 64'd1 << 29;
            end
            ST_T:
            begin
                alu_req.a = tmp_reg;
                alu_req.b = R_DIFF;
            end
            ST_R2:
            begin
                alu_req.a = tmp_reg;
                alu_req.b = R_SUM;
            end
            ST_RSQ:
            begin
                alu_op    = ALU_SQRT;
                alu_req.a = tmp_reg;
            end
            ST_TH:
            begin
                alu_req.a    = {31'd0, adlon_reg};
                alu_req.b    = {2'd0, cos_reg};
                alu_req.init = 64'd1 << 29;
            end
            ST_HM:
            begin
                alu_req.a    = tmp_reg;
                alu_req.b    = {1'b0, R2_Q8};
                alu_req.init = 64'd128;
            end
            ST_H, ST_V:
            begin
                alu_req.a    = tmp_reg;
                alu_req.b    = MUL_100;
                alu_req.init = 64'd1 << 28;
            end
            ST_VM:
            begin
                alu_req.a    = {32'd0, adlat_reg};
                alu_req.b    = {2'd0, radius_reg};
                alu_req.init = 64'd128;
            end
            ST_HH:
            begin
                alu_req.a = {32'd0, h_reg[31:0]};
                alu_req.b = {1'b0, h_reg[31:0]};
            end
            ST_VV:
            begin
                alu_req.a    = {32'd0, v_reg[31:0]};
                alu_req.b    = {1'b0, v_reg[31:0]};
                alu_req.init = tmp_reg;
            end
            ST_DSQ:
            begin
                alu_op    = ALU_SQRT;
                alu_req.a = tmp_reg;
            end
            default:
            begin
                alu_state = 1'b0;
            end
        endcase
        alu_req.op    = alu_op;
        alu_req.start = alu_state && !pend_reg;
    end

    fed_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    fed_cordic #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cos_start),
        .angle (lat1_reg),
        .rsp   (cos_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            thr_reg       <= 21'd8000;
            ref_reg       <= '0;
            radius_reg    <= R1_Q8[30:0];
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (alu_req.start || cos_start)
            begin
                pend_reg <= 1'b1;
            end
            else if (alu_fire || (pend_reg && cos_rsp.done))
            begin
                pend_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        state_reg <= ST_LAT;
                    end
                end
                ST_LAT:  if (alu_fire) state_reg <= ST_DLAT;
                ST_DLAT: if (alu_fire) state_reg <= ST_DLON;
                ST_DLON: if (alu_fire) state_reg <= ST_COS;
                ST_COS:  if (pend_reg && cos_rsp.done) state_reg <= ST_CHK;
                ST_CHK:
                begin
                    if (alu_fire)
                    begin
                        state_reg <= (thr_scaled < res[63:0]) ? ST_C2 : ST_TH;
                    end
                end
                ST_C2:   if (alu_fire) state_reg <= ST_T;
                ST_T:    if (alu_fire) state_reg <= ST_R2;
                ST_R2:   if (alu_fire) state_reg <= ST_RSQ;
                ST_RSQ:
                begin
                    if (alu_fire)
                    begin
                        radius_reg <= res[30:0];
                        ref_reg    <= lat1_s;
                        state_reg  <= ST_TH;
                    end
                end
                ST_TH:   if (alu_fire) state_reg <= ST_HM;
                ST_HM:   if (alu_fire) state_reg <= ST_H;
                ST_H:    if (alu_fire) state_reg <= ST_VM;
                ST_VM:   if (alu_fire) state_reg <= ST_V;
                ST_V:
                begin
                    if (alu_fire)
                    begin
                        state_reg <= ((h_reg[34:32] != '0) || (res[63:61] != '0)) ? ST_FIN
                                                                                  : ST_HH;
                    end
                end
                ST_HH:   if (alu_fire) state_reg <= ST_VV;
                ST_VV:   if (alu_fire) state_reg <= res[64] ? ST_FIN : ST_DSQ;
                ST_DSQ:  if (alu_fire) state_reg <= ST_FIN;
                ST_FIN:  if (out_load) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            lat_neg_reg  <= la[31];
            lat_mag_reg  <= la[31] ? 31'(-la) : 31'(la);
            dlat_mag_reg <= dlat[31] ? 32'(-dlat) : 32'(dlat);
            dlon_mag_reg <= dlon[32] ? 33'(-dlon) : 33'(dlon);
        end
        if (pend_reg && cos_rsp.done)
        begin
            cos_reg <= cos_rsp.cos_q30;
        end
        if (out_load)
        begin
            dist_reg <= rdist_reg;
            sat_reg  <= rsat_reg;
        end
        if (alu_fire)
        begin
            unique case (state_reg)
                ST_LAT:  lat1_reg  <= res[61:31];
                ST_DLAT: adlat_reg <= res[62:31];
                ST_DLON: adlon_reg <= res[63:31];
                ST_C2:   tmp_reg   <= 64'(res[64:30]);
                ST_T:    tmp_reg   <= 64'(res[64:20]);
                ST_R2:   tmp_reg   <= R1_SQ + 64'(res[64:10]);
                ST_TH:   tmp_reg   <= 64'(res[64:30]);
                ST_HM:   tmp_reg   <= 64'(res[64:8]);
                ST_H:    h_reg     <= res[63:29];
                ST_VM:   tmp_reg   <= 64'(res[64:8]);
                ST_V:
                begin
                    v_reg     <= res[63:29];
                    rdist_reg <= '1;
                    rsat_reg  <= 1'b1;
                end
                ST_HH:   tmp_reg   <= res[63:0];
                ST_VV:   tmp_reg   <= res[63:0];
                ST_DSQ:
                begin
                    rdist_reg <= res[31:0];
                    rsat_reg  <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    `FED_ASSERT_IMPLY(a_alu_start_idle, alu_req.start, !alu_rsp.busy)
    `FED_ASSERT_IMPLY(a_ready_units_idle, s_axis_tready, (!alu_rsp.busy && !cos_rsp.busy))
    `FED_ASSERT_NEXT(a_radius_hold, (state_reg != ST_RSQ), $stable(radius_reg))
    `FED_ASSERT_NEXT(a_fin_stall, fin_stall, (state_reg == ST_FIN))

endmodule
